// ===== src/sbqd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the stereo biquad lowpass with dither.
// No dependencies; imported by the lane, noise and top-level modules.
package sbqd_pkg;

   localparam int COEF_BITS      = 32;
   localparam int NOISE_BITS     = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B0    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A1    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A2    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEED_LEFT  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEED_RIGHT = 3'd4;

   localparam logic signed [COEF_BITS-1:0] COEF_B0_RESET = 32'sd203258000;
   localparam logic signed [COEF_BITS-1:0] COEF_A1_RESET = 32'sd390390000;
   localparam logic signed [COEF_BITS-1:0] COEF_A2_RESET = 32'sd154109000;
   localparam logic [NOISE_BITS-1:0] SEED_LEFT_RESET  = 32'd2463534242;
   localparam logic [NOISE_BITS-1:0] SEED_RIGHT_RESET = 32'd88172645;

   // xorshift32 taps and the offset that centers the noise
   localparam int XS_SHIFT_A = 13;
   localparam int XS_SHIFT_B = 17;
   localparam int XS_SHIFT_C = 5;
   localparam logic [NOISE_BITS-1:0] DITHER_OFFSET = 32'h7fffffff;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] b0;
      logic signed [COEF_BITS-1:0] a1;
      logic signed [COEF_BITS-1:0] a2;
   } coef_type;

   // take: a new sample enters the feedforward stage
   // step: the feedforward result moves into the recursive stage
   typedef struct packed {
      logic take;
      logic step;
   } lane_ctl_type;

endpackage

// ===== src/sbqd_noise.sv =====
`timescale 1ns / 1ps
// xorshift32 dither source for one channel: state, seed load, offset and shift.
// Depends on sbqd_pkg.
module sbqd_noise
   import sbqd_pkg::*;
#(
   parameter int EXTRA_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [NOISE_BITS-1:0]             reset_value,
   input  logic                              load,
   input  logic [NOISE_BITS-1:0]             seed,
   input  logic                              advance,
   output logic signed [EXTRA_FRAC_BITS+1:0] dither
);

   localparam int DITHER_SHIFT = 31 - EXTRA_FRAC_BITS;

   logic [NOISE_BITS-1:0]  state_ff;
   logic [NOISE_BITS-1:0]  state_in;
   logic [NOISE_BITS-1:0]  state_next;
   logic signed [NOISE_BITS:0] centered;
   logic signed [NOISE_BITS:0] centered_sh;

   always_comb begin
      logic [NOISE_BITS-1:0] t;
      t = state_ff ^ (state_ff << XS_SHIFT_A);
      t = t ^ (t >> XS_SHIFT_B);
      t = t ^ (t << XS_SHIFT_C);
      state_next = t;
   end

   // dither belongs to the advanced state
   assign centered    = $signed({1'b0, state_next}) - $signed({1'b0, DITHER_OFFSET});
   assign centered_sh = centered >>> DITHER_SHIFT;
   assign dither      = centered_sh[EXTRA_FRAC_BITS+1:0];

   always_comb begin
      state_in = state_ff;
      if (load) begin
         state_in = seed;
      end else if (advance) begin
         state_in = state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= reset_value;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/sbqd_lane.sv =====
`timescale 1ns / 1ps
// One channel: feedforward product stage, recursive biquad stage, dither and
// output rounding. Depends on sbqd_pkg and sbqd_noise.
module sbqd_lane
   import sbqd_pkg::*;
#(
   parameter int SAMPLE_BITS     = 24,
   parameter int EXTRA_FRAC_BITS = 16,
   parameter int COEF_FRAC_BITS  = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lane_ctl_type                  ctl,
   input  coef_type                      coef,
   input  logic [NOISE_BITS-1:0]         seed_init,
   input  logic                          seed_load,
   input  logic [NOISE_BITS-1:0]         seed,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   output logic signed [SAMPLE_BITS-1:0] sample_out
);

   localparam int W         = SAMPLE_BITS + EXTRA_FRAC_BITS;
   localparam int FF_BITS   = SAMPLE_BITS + 2;
   localparam int PROD_BITS = COEF_BITS + FF_BITS;
   localparam int FB_BITS   = COEF_BITS + W;
   localparam int ACC_BITS  = COEF_BITS + W + 3;
   localparam int D_BITS    = EXTRA_FRAC_BITS + 2;
   localparam int SUM_BITS  = W + 1;

   localparam logic signed [ACC_BITS-1:0] WIDE_MAX =
      {{(ACC_BITS-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] WIDE_MIN = ~WIDE_MAX;
   localparam logic signed [SUM_BITS-1:0] OUT_MAX =
      {{(SUM_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] OUT_MIN = ~OUT_MAX;

   logic signed [SAMPLE_BITS-1:0] in1_ff, in2_ff;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [W-1:0]           y1_ff, y2_ff, y_in;
   logic signed [D_BITS-1:0]      dither_ff, dither;
   logic signed [FF_BITS-1:0]     ff_sum;
   logic signed [FB_BITS-1:0]     fb1, fb2;
   logic signed [ACC_BITS-1:0]    acc, acc_sh;
   logic signed [SUM_BITS-1:0]    out_sum, out_sh;

   sbqd_noise #(
      .EXTRA_FRAC_BITS(EXTRA_FRAC_BITS)
   ) u_noise (
      .clock      (clock),
      .reset      (reset),
      .reset_value(seed_init),
      .load       (seed_load),
      .seed       (seed),
      .advance    (ctl.step),
      .dither     (dither)
   );

   // stage 1: x + 2*x1 + x2 times b0
   assign ff_sum  = FF_BITS'(sample_in) + (FF_BITS'(in1_ff) <<< 1) + FF_BITS'(in2_ff);
   assign prod_in = coef.b0 * ff_sum;

   // stage 2: recursion, floor shift, saturate to the wide format
   assign fb1    = coef.a1 * y1_ff;
   assign fb2    = coef.a2 * y2_ff;
   assign acc    = (ACC_BITS'(prod_ff) <<< EXTRA_FRAC_BITS) - ACC_BITS'(fb1) - ACC_BITS'(fb2);
   assign acc_sh = acc >>> COEF_FRAC_BITS;

   always_comb begin
      if (acc_sh > WIDE_MAX) begin
         y_in = WIDE_MAX[W-1:0];
      end else if (acc_sh < WIDE_MIN) begin
         y_in = WIDE_MIN[W-1:0];
      end else begin
         y_in = acc_sh[W-1:0];
      end
   end

   // output: y1 holds the newest filtered value
   assign out_sum = SUM_BITS'(y1_ff) + SUM_BITS'(dither_ff);
   assign out_sh  = out_sum >>> EXTRA_FRAC_BITS;

   always_comb begin
      if (out_sh > OUT_MAX) begin
         sample_out = OUT_MAX[SAMPLE_BITS-1:0];
      end else if (out_sh < OUT_MIN) begin
         sample_out = OUT_MIN[SAMPLE_BITS-1:0];
      end else begin
         sample_out = out_sh[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in1_ff <= '0;
         in2_ff <= '0;
         y1_ff  <= '0;
         y2_ff  <= '0;
      end else begin
         if (ctl.take) begin
            in1_ff <= sample_in;
            in2_ff <= in1_ff;
         end
         if (ctl.step) begin
            y1_ff <= y_in;
            y2_ff <= y1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take) begin
         prod_ff <= prod_in;
      end
      if (ctl.step) begin
         dither_ff <= dither;
      end
   end

endmodule

// ===== src/stereo_biquad_lowpass_dither.sv =====
`timescale 1ns / 1ps
// Stereo biquad lowpass with xorshift dither: two lanes and the merging
// output register. Depends on sbqd_pkg, sbqd_lane, sbqd_noise.
//
// Usage
//   req_*  : one word per stereo sample pair, left in the low half of tdata.
//   rsp_*  : one word per pair, filtered and dithered, same packing.
//   csr_*  : write-only registers (b0, a1, a2, left seed, right seed), taken
//            on any clock with csr_we high; write only while idle. A seed
//            write reloads that channel's noise generator.
// Throughput: one word per cycle unless rsp_tready stalls the output. Each lane
//   has a feedforward multiply stage and a recursive stage whose two feedback
//   multiplies and the accumulate close the y1/y2 loop with no register
//   beyond y1 and y2; that loop sets the one-word-per-cycle rate.
// Path: an accepted word is registered in the feedforward stage, then in
//   the recursive stage, then in the output register that drives rsp_tvalid.
// Stall: each stage moves when the one after it is empty or moving, so
//   while rsp_tready is low the two inner stages still fill; req_tready
//   drops only once all three hold words.
// Reset: synchronous, active high. Clears the filter history, loads the
//   seed reset values into the generators, restores default coefficients
//   and empties the pipeline.
module stereo_biquad_lowpass_dither
   import sbqd_pkg::*;
#(
   parameter int SAMPLE_BITS     = 24,
   parameter int EXTRA_FRAC_BITS = 16,
   parameter int COEF_FRAC_BITS  = 28,
   localparam int DATA_BITS      = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [DATA_BITS-1:0]      req_tdata,  // sample_left, sample_right
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [DATA_BITS-1:0]      rsp_tdata,  // out_left, out_right
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   coef_type     coef_ff;
   lane_ctl_type lane_ctl;

   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic [DATA_BITS-1:0] rsp_data_ff;
   logic en1, en2, en3;
   logic seed_load_left, seed_load_right;
   logic signed [SAMPLE_BITS-1:0] out_left, out_right;

   // stage advance chain
   assign en3 = !rsp_valid_ff || rsp_tready;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign req_tready    = en1;
   assign lane_ctl.take = req_tvalid && en1;
   assign lane_ctl.step = s1_valid_ff && en2;

   assign seed_load_left  = csr_we && (csr_index == CSR_SEED_LEFT);
   assign seed_load_right = csr_we && (csr_index == CSR_SEED_RIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= COEF_B0_RESET;
         coef_ff.a1 <= COEF_A1_RESET;
         coef_ff.a2 <= COEF_A2_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COEF_B0: begin
               coef_ff.b0 <= csr_data;
            end
            CSR_COEF_A1: begin
               coef_ff.a1 <= csr_data;
            end
            CSR_COEF_A2: begin
               coef_ff.a2 <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   sbqd_lane #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .EXTRA_FRAC_BITS(EXTRA_FRAC_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .ctl       (lane_ctl),
      .coef      (coef_ff),
      .seed_init (SEED_LEFT_RESET),
      .seed_load (seed_load_left),
      .seed      (csr_data),
      .sample_in (req_tdata[SAMPLE_BITS-1:0]),
      .sample_out(out_left)
   );

   sbqd_lane #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .EXTRA_FRAC_BITS(EXTRA_FRAC_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .ctl       (lane_ctl),
      .coef      (coef_ff),
      .seed_init (SEED_RIGHT_RESET),
      .seed_load (seed_load_right),
      .seed      (csr_data),
      .sample_in (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .sample_out(out_right)
   );

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_valid_ff <= req_tvalid;
         end
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (en3) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // merge both lanes into the output word; pad bits stay zero
   always_ff @(posedge clock) begin
      if (en3 && s2_valid_ff) begin
         rsp_data_ff <= DATA_BITS'({out_right, out_left});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/sbqd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the stereo biquad block, bound to the top level.
// Depends on stereo_biquad_lowpass_dither's port list.
module sbqd_checker #(
   parameter int DATA_BITS = 48
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [DATA_BITS-1:0] rsp_tdata
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // back-pressure reaches the input only when the output is stalled
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without an output stall");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // a word accepted while the output has been idle is not lost in the pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid && $past(!rsp_tvalid) &&
      $past(!rsp_tvalid, 2) ##0 1 |-> 1 ##3 (rsp_tvalid || $past(rsp_tvalid && rsp_tready)))
      else $error("word lost in pipeline");

endmodule

bind stereo_biquad_lowpass_dither sbqd_checker #(
   .DATA_BITS(DATA_BITS)
) u_sbqd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

// ===== tb/tb_stereo_biquad_lowpass_dither.sv =====
`timescale 1ns / 1ps
// Self-checking bench for stereo_biquad_lowpass_dither: random stream traffic
// with stalls on both sides, checked word by word against an in-bench model.
// Depends on sbqd_pkg and the block's RTL.
module tb_stereo_biquad_lowpass_dither;
   import sbqd_pkg::*;

   localparam int SAMPLE_BITS     = 24;
   localparam int EXTRA_FRAC_BITS = 16;
   localparam int COEF_FRAC_BITS  = 28;
   localparam int WIDE_BITS       = SAMPLE_BITS + EXTRA_FRAC_BITS;
   localparam int DATA_BITS       = 48;
   localparam int LIMIT_CYCLES    = 1000000;
   localparam int DRAIN_CYCLES    = 8;     // pipeline is three deep
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_WORDS     = 140;

   // indexes past the last register; writes there must change nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LO = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_HI = 3'd7;

   // coefficient flavors per phase
   localparam int KIND_NEAR_DEFAULT = 0;
   localparam int KIND_ANY          = 2;
   localparam int KIND_EXTREME      = 3;

   localparam logic signed [79:0] WIDE_MAX = 80'sh7f_ffff_ffff;
   localparam logic signed [79:0] WIDE_MIN = -80'sh80_0000_0000;
   localparam logic signed [WIDE_BITS:0] OUT_MAX = 41'sd8388607;
   localparam logic signed [WIDE_BITS:0] OUT_MIN = -41'sd8388608;

   localparam logic [SAMPLE_BITS-1:0] S_MAX  = 24'h7fffff;
   localparam logic [SAMPLE_BITS-1:0] S_MIN  = 24'h800000;
   localparam logic [SAMPLE_BITS-1:0] S_ZERO = 24'h000000;

   // one stereo word as it sits in tdata: left in the low half
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] right;
      logic [SAMPLE_BITS-1:0] left;
   } stereo_word_type;

   // filter history and dither generator of one channel
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] in1;
      logic signed [SAMPLE_BITS-1:0] in2;
      logic signed [WIDE_BITS-1:0]   out1;
      logic signed [WIDE_BITS-1:0]   out2;
      logic [NOISE_BITS-1:0]         noise;
   } lane_hist_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [DATA_BITS-1:0]      req_tdata  = '0;   // sample_left, sample_right
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [DATA_BITS-1:0]      rsp_tdata;         // out_left, out_right
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;

   stereo_biquad_lowpass_dither dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // model state: coefficients and both channels
   logic signed [COEF_BITS-1:0] b0_reg, a1_reg, a2_reg;
   lane_hist_type               hist_left, hist_right;

   stereo_word_type pending_pairs[$];    // words waiting for the driver
   stereo_word_type expected_pairs[$];   // filtered words still owed by the DUT

   int  queued_count   = 0;
   int  accepted_count = 0;
   int  checked_count  = 0;
   int  mismatches     = 0;
   int  settings_count = 0;
   int  cycle_count    = 0;
   int  req_gap        = 0;
   int  rsp_hold       = 0;
   logic req_took      = 1'b0;   // word on req was taken at the last rising edge
   logic calm          = 1'b0;   // no idling on either side while set

   // One channel of the filter plus dither; advances that channel's history.
   function automatic logic [SAMPLE_BITS-1:0] lowpass_dither_lane(
      inout lane_hist_type h, input logic signed [SAMPLE_BITS-1:0] x);
      logic signed [79:0]          ff;
      logic signed [79:0]          acc;
      logic signed [79:0]          shifted;
      logic signed [WIDE_BITS-1:0] y;
      logic [NOISE_BITS-1:0]       n;
      logic signed [33:0]          centered;
      logic signed [33:0]          dith;
      logic signed [WIDE_BITS:0]   sum;
      logic signed [WIDE_BITS:0]   o;
      // b1 = 2*b0 and b2 = b0, so the feedforward part is one product
      ff = (x + 2 * $signed(h.in1) + $signed(h.in2)) <<< EXTRA_FRAC_BITS;
      acc = b0_reg * ff - a1_reg * $signed(h.out1) - a2_reg * $signed(h.out2);
      shifted = acc >>> COEF_FRAC_BITS;
      if (shifted > WIDE_MAX) begin
         y = WIDE_MAX[WIDE_BITS-1:0];
      end else if (shifted < WIDE_MIN) begin
         y = WIDE_MIN[WIDE_BITS-1:0];
      end else begin
         y = shifted[WIDE_BITS-1:0];
      end
      h.in2  = h.in1;
      h.in1  = x;
      h.out2 = h.out1;
      h.out1 = y;
      // xorshift32, stepped before use
      n = h.noise;
      n = n ^ (n << XS_SHIFT_A);
      n = n ^ (n >> XS_SHIFT_B);
      n = n ^ (n << XS_SHIFT_C);
      h.noise = n;
      centered = $signed({2'b00, n}) - $signed({2'b00, DITHER_OFFSET});
      dith = centered >>> (31 - EXTRA_FRAC_BITS);
      sum = y + dith;
      o = sum >>> EXTRA_FRAC_BITS;
      if (o > OUT_MAX) begin
         return OUT_MAX[SAMPLE_BITS-1:0];
      end else if (o < OUT_MIN) begin
         return OUT_MIN[SAMPLE_BITS-1:0];
      end
      return o[SAMPLE_BITS-1:0];
   endfunction

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(9))
         0: begin
            return $urandom_range(1) ? S_MAX : S_MIN;
         end
         1, 2: begin
            return SAMPLE_BITS'($urandom_range(2047) - 1024);
         end
         default: begin
            return SAMPLE_BITS'($urandom());
         end
      endcase
   endfunction

   function automatic logic [COEF_BITS-1:0] rand_coef(input int kind,
                                                      input logic [COEF_BITS-1:0] dflt);
      if (kind == KIND_ANY) begin
         return $urandom();
      end else if (kind == KIND_EXTREME) begin
         case ($urandom_range(4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return 32'h00000001;
            default: return 32'hffffffff;
         endcase
      end
      // small offset around the default keeps the poles inside
      return dflt + ($urandom_range(8388607) - 32'd4194304);
   endfunction

   function automatic logic [NOISE_BITS-1:0] rand_seed();
      case ($urandom_range(9))
         0: return '0;
         1: return $urandom_range(16385, 1);
         2: return 32'hffffffff;
         default: return $urandom();
      endcase
   endfunction

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("tb_stereo_biquad_lowpass_dither: errors");
         $finish;
      end
   end

   // Monitor: follows csr writes, predicts each accepted req word and
   // checks each accepted rsp word against the oldest prediction.
   always @(posedge clock) begin
      stereo_word_type in_w;
      stereo_word_type got;
      stereo_word_type want;
      if (reset) begin
         b0_reg     <= COEF_B0_RESET;
         a1_reg     <= COEF_A1_RESET;
         a2_reg     <= COEF_A2_RESET;
         hist_left  <= '{in1: '0, in2: '0, out1: '0, out2: '0, noise: SEED_LEFT_RESET};
         hist_right <= '{in1: '0, in2: '0, out1: '0, out2: '0, noise: SEED_RIGHT_RESET};
         req_took   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_COEF_B0:    b0_reg = csr_data;
               CSR_COEF_A1:    a1_reg = csr_data;
               CSR_COEF_A2:    a2_reg = csr_data;
               CSR_SEED_LEFT:  hist_left.noise = csr_data;
               CSR_SEED_RIGHT: hist_right.noise = csr_data;
               default: ;   // unused index
            endcase
         end
         req_took <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            in_w = req_tdata;
            want.left  = lowpass_dither_lane(hist_left, in_w.left);
            want.right = lowpass_dither_lane(hist_right, in_w.right);
            expected_pairs.push_back(want);
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_pairs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected rsp word %h at cycle %0d", got, cycle_count);
            end else begin
               want = expected_pairs.pop_front();
               checked_count++;
               if (got.left !== want.left || got.right !== want.right) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("word %0d: left exp %h got %h, right exp %h got %h",
                              checked_count, want.left, got.left, want.right, got.right);
               end
            end
         end
      end
   end

   // Driver: req words from the pending queue, random gaps, random rsp stalls.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
         req_gap    <= 0;
         rsp_hold   <= 0;
      end else begin
         if (!req_tvalid || req_took) begin
            if (req_gap > 0) begin
               req_tvalid <= 1'b0;
               req_gap    <= req_gap - 1;
            end else if (pending_pairs.size() > 0) begin
               req_tdata  <= pending_pairs.pop_front();
               req_tvalid <= 1'b1;
               req_gap    <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= rsp_hold - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_hold   <= pick_gap();
         end
      end
   end

   // one register write; drops csr_we again and leaves it low before the task returns
   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   task automatic push_pair(input logic [SAMPLE_BITS-1:0] l,
                            input logic [SAMPLE_BITS-1:0] r);
      stereo_word_type w;
      w.left  = l;
      w.right = r;
      pending_pairs.push_back(w);
      queued_count++;
   endtask

   // everything sent has been taken and answered, then a short drain
   task automatic wait_idle();
      while (accepted_count != queued_count || expected_pairs.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int kind;
      int left_over;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults after reset: full-scale steps and patterns
      settings_count++;
      push_pair(S_ZERO, S_ZERO);
      push_pair(S_MAX, S_MIN);
      push_pair(S_MIN, S_MAX);
      repeat (3) push_pair(S_MAX, S_MAX);
      repeat (3) push_pair(S_MIN, S_MIN);
      push_pair(S_ZERO, S_ZERO);
      push_pair(24'h555555, 24'haaaaaa);
      wait_idle();

      // zero seed (dither stuck low), tiny seed, writes to unused indexes,
      // and unstable coefficients that drive the history into saturation
      settings_count++;
      csr_write(CSR_SEED_LEFT, 32'h00000000);
      csr_write(CSR_SEED_RIGHT, 32'h00000001);
      csr_write(CSR_UNUSED_LO, 32'hffffffff);
      csr_write(CSR_UNUSED_HI, 32'h12345678);
      csr_write(CSR_COEF_B0, 32'h7fffffff);
      csr_write(CSR_COEF_A1, 32'h80000000);
      csr_write(CSR_COEF_A2, 32'h7fffffff);
      repeat (3) push_pair(S_MAX, S_MAX);
      repeat (3) push_pair(S_MIN, S_MIN);
      repeat (2) push_pair(S_ZERO, S_ZERO);
      wait_idle();

      // random phases: new settings between them, random content inside
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         kind = p % 4;
         calm = (p % 3 == 1);
         settings_count++;
         csr_write(CSR_COEF_B0, rand_coef(kind, COEF_B0_RESET));
         csr_write(CSR_COEF_A1, rand_coef(kind, COEF_A1_RESET));
         csr_write(CSR_COEF_A2, rand_coef(kind, COEF_A2_RESET));
         if ($urandom_range(1)) csr_write(CSR_SEED_LEFT, rand_seed());
         if ($urandom_range(1)) csr_write(CSR_SEED_RIGHT, rand_seed());
         if ($urandom_range(3) == 0)
            csr_write(CSR_INDEX_BITS'($urandom_range(CSR_UNUSED_HI, CSR_UNUSED_LO)),
                      $urandom());
         for (int i = 0; i < PHASE_WORDS; i++)
            push_pair(rand_sample(), rand_sample());
         wait_idle();
      end
      calm = 1'b0;

      left_over = expected_pairs.size();
      if (left_over != 0) begin
         mismatches += left_over;
         $display("%0d expected words never arrived", left_over);
      end
      $display("covered %0d stereo words under %0d coefficient/seed settings",
               accepted_count, settings_count);
      $display("%0d result words checked, %0d mismatches", checked_count, mismatches);
      if (mismatches == 0) begin
         $display("tb_stereo_biquad_lowpass_dither: clean");
      end else begin
         $display("tb_stereo_biquad_lowpass_dither: errors");
      end
      $finish;
   end

endmodule
